>>> design/track_slot_assigner_defines.svh
// ----------------------------------------------------------------------------
// Track slot assigner assertion macros
// Shared helpers for concurrent checks on the track slot assigner.
// ----------------------------------------------------------------------------
`ifndef TRACK_SLOT_ASSIGNER_DEFINES_SVH
`define TRACK_SLOT_ASSIGNER_DEFINES_SVH

// Check clocked on clk_i, held off while reset is asserted.
`define TSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check clocked on clk_i that also holds during reset.
`define TSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/tsa_pkg.sv
// ----------------------------------------------------------------------------
// Track slot assigner package
// Shared types and fixed widths of the track slot assigner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsa_pkg;

  localparam int WORD_W     = 32;
  localparam int TRACK_IN_W = 16;
  localparam int SLOT_NUM_W = 6;

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [TRACK_IN_W-1:0] track_in_t;
  typedef logic [SLOT_NUM_W-1:0] slot_num_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MARK,
    ST_NEXT,
    ST_SCAN,
    ST_WRITE,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT,
    ST_FREE
  } state_e;

endpackage

`default_nettype wire

>>> design/tsa_frame_store.sv
// ----------------------------------------------------------------------------
// Track slot assigner frame store
// Ping-pong store of frame triplets, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsa_frame_store #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 80
) (
  input  wire logic                       clk_i,
  input  wire logic                       wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  wire logic [WIDTH-1:0]           wr_data_i,
  input  wire logic                       rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output logic      [WIDTH-1:0]           rd_data_o
);
  import tsa_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/track_slot_assigner.sv
// ----------------------------------------------------------------------------
// Track slot assigner
// Collects frames of (track, freq, amp) triplets, assigns tracks to oscillator slots
// and at frame end emits one (freq, amp) pair per slot below high-water, or an empty list.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  ---------------------------------
//  in       sink       in_valid_i / in_stall_o   track_id, freq_word, amp_word,
//                                                has_triplet, frame_end
//  out      source     out_valid_o / out_stall_i slot_number, out_freq, out_amp,
//                                                empty_list, last_pair
//
//  A request without frame end leaves the block ready again next cycle.
//  After a frame end, every triplet of both frames gets a slot scan, which reads and
//  compares one slot track per cycle across all SLOTS slots.
//  Reset clears all control state and slot flags; the stores need no clearing pass.
//  While a result waits on out_stall_i, the block holds it and takes no request.
//
`timescale 1ns / 1ps
`default_nettype none

module track_slot_assigner #(
  parameter int SLOTS          = 64,
  parameter int FRAME_TRIPLETS = 256,
  parameter int TRACK_BITS     = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tsa_pkg::track_in_t track_id_i,
  input  wire tsa_pkg::word_t     freq_word_i,
  input  wire tsa_pkg::word_t     amp_word_i,
  input  wire logic               has_triplet_i,
  input  wire logic               frame_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tsa_pkg::slot_num_t      slot_number_o,
  output tsa_pkg::word_t          out_freq_o,
  output tsa_pkg::word_t          out_amp_o,
  output logic                    empty_list_o,
  output logic                    last_pair_o
);
  import tsa_pkg::*;

  // Stored track width: the input is masked to TRACK_BITS, and never wider than the port.
  localparam int TW   = (TRACK_BITS < TRACK_IN_W) ? TRACK_BITS : TRACK_IN_W;
  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HW_W = $clog2(SLOTS + 1);
  localparam int FC_W = $clog2(FRAME_TRIPLETS + 1);
  localparam int AW   = $clog2(2 * FRAME_TRIPLETS);
  localparam int FS_W = TW + 2 * WORD_W;

  state_e state_q, state_d;

  // Frame bookkeeping.
  logic            half_q, half_d;
  logic [FC_W-1:0] fill_q, fill_d;
  logic [FC_W-1:0] fcnt_q [2];
  logic [FC_W-1:0] fcnt_d [2];
  logic            pass_q, pass_d;
  logic [FC_W-1:0] k_q, k_d;

  // Slot flags and high-water mark.
  logic [SLOTS-1:0] used_q, used_d;
  logic [SLOTS-1:0] dead_q, dead_d;
  logic [HW_W-1:0]  hw_q, hw_d;

  // Slot scan state.
  logic [HW_W-1:0] j_q, j_d;
  logic            chk_v_q, chk_v_d;
  logic [SW-1:0]   chk_idx_q, chk_idx_d;
  logic            match_q, match_d;
  logic [SW-1:0]   match_idx_q, match_idx_d;
  logic            free_q, free_d;
  logic [SW-1:0]   free_idx_q, free_idx_d;

  // Output walk.
  logic [HW_W-1:0] o_q, o_d;
  logic            out_valid_q, out_valid_d;
  slot_num_t       slot_num_q, slot_num_d;
  word_t           out_freq_q, out_freq_d;
  word_t           out_amp_q, out_amp_d;
  logic            empty_q, empty_d;
  logic            last_q, last_d;

  // Frame store ports.
  logic            fs_we, fs_re;
  logic [AW-1:0]   fs_waddr, fs_raddr;
  logic [FS_W-1:0] fs_wdata, fs_rdata;
  logic [TW-1:0]   fs_track;
  word_t           fs_freq, fs_amp;

  // Slot tables: track, frequency and amplitude of each slot.
  logic [TW-1:0] trk_mem  [SLOTS];
  word_t         freq_mem [SLOTS];
  word_t         amp_mem  [SLOTS];
  logic [TW-1:0] trk_rd_q;
  word_t         freq_rd_q, amp_rd_q;

  logic          slot_we;
  logic [SW-1:0] slot_wa;
  logic [TW-1:0] slot_wtrk;
  word_t         slot_wfreq, slot_wamp;
  logic          trk_re, out_re;

  logic [SLOTS-1:0] below_hw;
  logic             accept, store_it, cur_half;
  logic [FC_W-1:0]  fill_inc;

  assign accept   = in_valid_i && !in_stall_o;
  assign store_it = has_triplet_i && (fill_q < FC_W'(FRAME_TRIPLETS));
  assign fill_inc = fill_q + FC_W'(store_it);
  assign cur_half = pass_q ? ~half_q : half_q;

  assign fs_we    = accept && store_it;
  assign fs_waddr = (~half_q) ? (AW'(FRAME_TRIPLETS) + AW'(fill_q)) : AW'(fill_q);
  assign fs_wdata = {track_id_i[TW-1:0], freq_word_i, amp_word_i};
  assign fs_raddr = cur_half ? (AW'(FRAME_TRIPLETS) + AW'(k_q)) : AW'(k_q);
  assign {fs_track, fs_freq, fs_amp} = fs_rdata;

  tsa_frame_store #(
    .DEPTH (2 * FRAME_TRIPLETS),
    .WIDTH (FS_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (fs_we),
    .wr_addr_i (fs_waddr),
    .wr_data_i (fs_wdata),
    .rd_en_i   (fs_re),
    .rd_addr_i (fs_raddr),
    .rd_data_o (fs_rdata)
  );

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      below_hw[i] = (HW_W'(i) < hw_q);
    end
  end

  // Slot tables: one write port, the track table read by the scan and the
  // frequency and amplitude tables read by the output walk.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      trk_mem[slot_wa]  <= slot_wtrk;
      freq_mem[slot_wa] <= slot_wfreq;
      amp_mem[slot_wa]  <= slot_wamp;
    end
    if (trk_re) begin
      trk_rd_q <= trk_mem[j_q[SW-1:0]];
    end
    if (out_re) begin
      freq_rd_q <= freq_mem[o_q[SW-1:0]];
      amp_rd_q  <= amp_mem[o_q[SW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      half_q      <= 1'b0;
      fill_q      <= '0;
      fcnt_q[0]   <= '0;
      fcnt_q[1]   <= '0;
      pass_q      <= 1'b0;
      k_q         <= '0;
      used_q      <= '0;
      dead_q      <= '0;
      hw_q        <= '0;
      j_q         <= '0;
      chk_v_q     <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      o_q         <= '0;
      out_valid_q <= 1'b0;
      empty_q     <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      half_q      <= half_d;
      fill_q      <= fill_d;
      fcnt_q[0]   <= fcnt_d[0];
      fcnt_q[1]   <= fcnt_d[1];
      pass_q      <= pass_d;
      k_q         <= k_d;
      used_q      <= used_d;
      dead_q      <= dead_d;
      hw_q        <= hw_d;
      j_q         <= j_d;
      chk_v_q     <= chk_v_d;
      match_q     <= match_d;
      free_q      <= free_d;
      o_q         <= o_d;
      out_valid_q <= out_valid_d;
      empty_q     <= empty_d;
      last_q      <= last_d;
    end
  end

  // Indexes and the result payload carry no reset.
  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    slot_num_q  <= slot_num_d;
    out_freq_q  <= out_freq_d;
    out_amp_q   <= out_amp_d;
  end

  always_comb begin
    state_d     = state_q;
    half_d      = half_q;
    fill_d      = fill_q;
    fcnt_d[0]   = fcnt_q[0];
    fcnt_d[1]   = fcnt_q[1];
    pass_d      = pass_q;
    k_d         = k_q;
    used_d      = used_q;
    dead_d      = dead_q;
    hw_d        = hw_q;
    j_d         = j_q;
    chk_v_d     = chk_v_q;
    chk_idx_d   = chk_idx_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    o_d         = o_q;
    out_valid_d = out_valid_q;
    slot_num_d  = slot_num_q;
    out_freq_d  = out_freq_q;
    out_amp_d   = out_amp_q;
    empty_d     = empty_q;
    last_d      = last_q;
    fs_re       = 1'b0;
    trk_re      = 1'b0;
    out_re      = 1'b0;
    slot_we     = 1'b0;
    slot_wa     = match_idx_q;
    slot_wtrk   = fs_track;
    slot_wfreq  = fs_freq;
    slot_wamp   = fs_amp;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (frame_end_i) begin
            fcnt_d[~half_q] = fill_inc;
            fill_d          = '0;
            state_d         = ST_MARK;
          end else begin
            fill_d = fill_inc;
          end
        end
      end

      // Every slot below high-water starts the frame as dead.
      ST_MARK: begin
        dead_d  = dead_q | below_hw;
        pass_d  = 1'b0;
        k_d     = '0;
        state_d = ST_NEXT;
      end

      // Fetch the next triplet of the present frame, then of the new frame.
      ST_NEXT: begin
        if (k_q < fcnt_q[cur_half]) begin
          fs_re   = 1'b1;
          j_d     = '0;
          chk_v_d = 1'b0;
          match_d = 1'b0;
          free_d  = 1'b0;
          state_d = ST_SCAN;
        end else if (!pass_q) begin
          pass_d = 1'b1;
          k_d    = '0;
        end else if (hw_q == '0) begin
          out_valid_d = 1'b1;
          slot_num_d  = '0;
          out_freq_d  = '0;
          out_amp_d   = '0;
          empty_d     = 1'b1;
          last_d      = 1'b1;
          state_d     = ST_OUT_WAIT;
        end else begin
          o_d     = '0;
          state_d = ST_OUT_RD;
        end
      end

      // One slot per cycle: the track read issued last cycle is compared now,
      // looking for a matching used slot below high-water and the first free slot.
      ST_SCAN: begin
        if (j_q < HW_W'(SLOTS)) begin
          trk_re = 1'b1;
          j_d    = j_q + 1'b1;
        end
        chk_v_d   = (j_q < HW_W'(SLOTS));
        chk_idx_d = j_q[SW-1:0];
        if (chk_v_q) begin
          if (!match_q && used_q[chk_idx_q] && (HW_W'(chk_idx_q) < hw_q) &&
              (trk_rd_q == fs_track)) begin
            match_d     = 1'b1;
            match_idx_d = chk_idx_q;
          end
          if (!free_q && !used_q[chk_idx_q]) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx_q;
          end
        end else if (j_q == HW_W'(SLOTS)) begin
          state_d = ST_WRITE;
        end
      end

      ST_WRITE: begin
        if (!pass_q) begin
          // Present frame: the track takes its slot with freq and amp, alive.
          if (match_q) begin
            slot_we = 1'b1;
            slot_wa = match_idx_q;
          end else if (free_q) begin
            slot_we = 1'b1;
            slot_wa = free_idx_q;
            if (HW_W'(free_idx_q) == hw_q) begin
              hw_d = hw_q + 1'b1;
            end
          end
        end else begin
          // New frame: a newborn track, or one whose slot died, starts silent.
          slot_wamp = '0;
          if (!match_q) begin
            if (free_q) begin
              slot_we = 1'b1;
              slot_wa = free_idx_q;
              if (HW_W'(free_idx_q) == hw_q) begin
                hw_d = hw_q + 1'b1;
              end
            end
          end else if (dead_q[match_idx_q]) begin
            slot_we = 1'b1;
            slot_wa = match_idx_q;
          end
        end
        if (slot_we) begin
          used_d[slot_wa] = 1'b1;
          dead_d[slot_wa] = 1'b0;
        end
        k_d     = k_q + 1'b1;
        state_d = ST_NEXT;
      end

      ST_OUT_RD: begin
        out_re  = 1'b1;
        state_d = ST_OUT_LD;
      end

      // A free slot reads as zero; a dead slot keeps its frequency but is silent.
      ST_OUT_LD: begin
        out_valid_d = 1'b1;
        slot_num_d  = SLOT_NUM_W'(o_q);
        out_freq_d  = used_q[o_q[SW-1:0]] ? freq_rd_q : '0;
        out_amp_d   = (used_q[o_q[SW-1:0]] && !dead_q[o_q[SW-1:0]]) ? amp_rd_q : '0;
        empty_d     = 1'b0;
        last_d      = (HW_W'(o_q + 1'b1) == hw_q);
        state_d     = ST_OUT_WAIT;
      end

      ST_OUT_WAIT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (last_q) begin
            state_d = ST_FREE;
          end else begin
            o_d     = o_q + 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end

      // Release dead slots; high-water drops only if the top slot died.
      ST_FREE: begin
        used_d = used_q & ~dead_q;
        dead_d = '0;
        if ((hw_q != '0) && dead_q[SW'(hw_q - 1'b1)]) begin
          hw_d = hw_q - 1'b1;
        end
        half_d  = ~half_q;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign slot_number_o = slot_num_q;
  assign out_freq_o    = out_freq_q;
  assign out_amp_o     = out_amp_q;
  assign empty_list_o  = empty_q;
  assign last_pair_o   = last_q;

endmodule

`default_nettype wire

>>> design/tsa_checker.sv
// ----------------------------------------------------------------------------
// Track slot assigner port checker
// Concurrent checks on the port behavior of the track slot assigner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "track_slot_assigner_defines.svh"

module tsa_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               frame_end_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire tsa_pkg::slot_num_t slot_number_o,
  input wire tsa_pkg::word_t     out_freq_o,
  input wire tsa_pkg::word_t     out_amp_o,
  input wire logic               empty_list_o,
  input wire logic               last_pair_o
);
  import tsa_pkg::*;

  // A stalled result holds its payload.
  `TSA_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_freq_o) && $stable(out_amp_o) && $stable(slot_number_o) && $stable(last_pair_o)), "stalled result changed")
  // No request is taken while a result is pending.
  `TSA_ASSERT_ALWAYS(a_busy_out, out_valid_o |-> in_stall_o, "request taken during output")
  // The empty list result is a single zero result that closes the frame.
  `TSA_ASSERT(a_empty, (out_valid_o && empty_list_o) |-> (last_pair_o && slot_number_o == '0 && out_freq_o == '0 && out_amp_o == '0), "bad empty list result")
  // A request inside a frame leaves the block ready.
  `TSA_ASSERT(a_mid_ready, (in_valid_i && !in_stall_o && !frame_end_i) |=> !in_stall_o, "stalled after mid frame request")
  // A frame end starts the slot update.
  `TSA_ASSERT(a_end_busy, (in_valid_i && !in_stall_o && frame_end_i) |=> in_stall_o, "ready after frame end")

endmodule

bind track_slot_assigner tsa_checker u_tsa_checker (.*);

`default_nettype wire
